// File: rtl/core/mbp_pkg.sv
// shared types and constants for the msb-first bit packer
package mbp_pkg;

   localparam int unsigned WORD_BYTES_DEF = 4;
   localparam int unsigned VALUE_WIDTH    = 32;
   localparam int unsigned COUNT_WIDTH    = 6;

   typedef enum logic [1:0] {
      OP_WRITE_BITS  = 2'd0,
      OP_WRITE_BYTES = 2'd1,
      OP_PAD_FLUSH   = 2'd2,
      OP_RAW_FLUSH   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ALIGN = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic align;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic nb_zero;
      logic nb_one;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/mbp_ctrl.sv
// controller state machine for the msb-first bit packer
module mbp_ctrl
   import mbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = status.nb_zero ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.nb_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/mbp_datapath.sv
// datapath for the msb-first bit packer: pending store, aligner and output register
module mbp_datapath
   import mbp_pkg::*;
#(
   parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_wdata,
   input  logic [1:0]             req_opcode,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [COUNT_WIDTH-1:0] req_count,
   input  logic                   req_reverse,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int unsigned DW  = 8 * WORD_BYTES;
   localparam int unsigned AW  = DW + 8;
   localparam int unsigned LW  = $clog2(AW);
   localparam int unsigned NBW = LW - 3;
   localparam int unsigned NW  = $clog2(DW + 1);
   localparam int unsigned BW  = $clog2(WORD_BYTES + 1);
   localparam logic [LW:0] AW_L = (LW + 1)'(AW);

   logic          hbe_ff;
   logic [7:0]    pend_bits_ff;
   logic [2:0]    pend_cnt_ff;
   logic [AW-1:0] ext_ff, ext_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] sr_ff;
   logic [NBW-1:0] nb_ff;
   logic          rsp_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          last_ff;

   opcode_type    op;
   logic [COUNT_WIDTH:0] cnt_x;
   logic [NW-1:0] n_bits;
   logic [BW-1:0] n_bytes;
   logic [NW-1:0] n_sel;
   logic [DW-1:0] vext;
   logic [DW-1:0] vmask;
   logic [DW-1:0] vrev;
   logic [DW-1:0] field;
   logic          high_first;
   logic          is_flush;
   logic [7:0]    flush_byte;
   logic [3:0]    pad_shift;

   assign op       = opcode_type'(req_opcode);
   assign cnt_x    = {1'b0, req_count};
   assign is_flush = (op == OP_PAD_FLUSH) || (op == OP_RAW_FLUSH);
   assign high_first = req_reverse ^ hbe_ff;
   assign vext     = DW'(req_value);
   assign pad_shift = 4'd8 - {1'b0, pend_cnt_ff};

   // clamp counts into their legal range
   always_comb begin
      if (cnt_x == '0) begin
         n_bits = NW'(1);
      end else if (cnt_x > (COUNT_WIDTH + 1)'(DW)) begin
         n_bits = NW'(DW);
      end else begin
         n_bits = NW'(cnt_x);
      end
      if (cnt_x == '0) begin
         n_bytes = BW'(1);
      end else if (cnt_x > (COUNT_WIDTH + 1)'(WORD_BYTES)) begin
         n_bytes = BW'(WORD_BYTES);
      end else begin
         n_bytes = BW'(cnt_x);
      end
   end

   // low-byte-first order: byte 0 goes out first, so it sits highest
   always_comb begin
      for (int j = 0; j < WORD_BYTES; j++) begin
         vrev[8*j +: 8] = 8'h00;
         if (j < int'(n_bytes)) begin
            vrev[8*j +: 8] = vext[8*(int'(n_bytes) - 1 - j) +: 8];
         end
      end
   end

   always_comb begin
      n_sel = (op == OP_WRITE_BYTES) ? (NW'(n_bytes) << 3) : n_bits;
      vmask = ~({DW{1'b1}} << n_sel);
      if ((op == OP_WRITE_BYTES) && !high_first) begin
         field = vrev;
      end else begin
         field = vext & vmask;
      end
   end

   always_comb begin
      if (op == OP_PAD_FLUSH) begin
         flush_byte = 8'(pend_bits_ff << pad_shift);
      end else begin
         flush_byte = pend_bits_ff;
      end
      if (is_flush) begin
         ext_in = AW'(flush_byte);
         len_in = LW'(8);
      end else begin
         ext_in = (AW'(pend_bits_ff) << n_sel) | AW'(field);
         len_in = LW'(pend_cnt_ff) + LW'(n_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hbe_ff       <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            hbe_ff <= csr_wdata;
         end
         if (cmd.load) begin
            pend_bits_ff <= ext_in[7:0] & ~(8'hFF << len_in[2:0]);
            pend_cnt_ff  <= len_in[2:0];
            nb_ff        <= len_in[LW-1:3];
         end else if (cmd.emit) begin
            nb_ff <= nb_ff - NBW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ext_ff <= ext_in;
         len_ff <= len_in;
      end
      if (cmd.align) begin
         sr_ff <= ext_ff << (AW_L - (LW + 1)'(len_ff));
      end else if (cmd.emit) begin
         sr_ff <= sr_ff << 8;
      end
      if (cmd.emit) begin
         out_byte_ff <= sr_ff[AW-1 -: 8];
         last_ff     <= (nb_ff == NBW'(1));
      end
   end

   assign status.nb_zero  = (nb_ff == '0);
   assign status.nb_one   = (nb_ff == NBW'(1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = last_ff;

`ifndef ASSERT_OFF
   a_emit_has_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (nb_ff != '0))
      else $error("byte emitted with none left");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   a_pending_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff == '0) |-> (pend_bits_ff == '0))
      else $error("stale bits in empty pending store");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && is_flush) |=> (pend_cnt_ff == '0) && (nb_ff == NBW'(1)))
      else $error("flush did not clear pending store");
`endif

endmodule

// File: rtl/core/msb_first_bit_packer.sv
// top level of the msb-first bit packer
//
// input channel req_*: one beat carries an operation (write bits, write bytes,
// pad-flush, raw-flush) with value, count and reverse flag
// result channel rsp_*: one beat per completed byte; rsp_last marks the final
// byte caused by an input beat; an input that completes no byte gives no beat
// csr_we / csr_wdata set the host byte order flag; the user writes it only
// while idle, which the block itself does not enforce
// an input beat is aligned in the cycle after the edge that takes it, and its
// first byte goes to the output register from the EMIT state once that is free
// an input beat completes n bytes (0 to WORD_BYTES); the single shift register
// serialises them, one byte per cycle while rsp_stall does not hold the output
// the output register lets the next input beat be taken while the last byte
// of the previous one still waits
// a stall on rsp_stall holds the output beat and pauses the byte sequencer;
// req_stall is high whenever an input beat is still being worked on
// reset (synchronous, active high) empties the pending bits, clears the
// byte order flag and drops rsp_valid
module msb_first_bit_packer
   import mbp_pkg::*;
#(
   parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic                   csr_wdata,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [COUNT_WIDTH-1:0] req_count,
   input  logic                   req_reverse,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last
);

   cmd_type    cmd;
   status_type status;

   // sequencer: accept, align, then one byte per free output slot
   mbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // pending store, field builder, aligner and output register
   mbp_datapath #(
      .WORD_BYTES (WORD_BYTES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_count    (req_count),
      .req_reverse  (req_reverse),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
